>>> sv/mcsr_pkg.sv
// Shared types, CSR numbers, cause codes and op codes for the machine-mode CSR and trap unit.
`timescale 1ns / 1ps

package mcsr_pkg;

    // Machine word width (RV32)
    localparam int unsigned XLEN = 32;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ISA_MASK  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IE_MASK   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COMPRESS  = 2'd2;

    // Configuration reset values
    localparam logic [25:0]     ISA_MASK_RST = 26'd256;
    localparam logic [XLEN-1:0] IE_MASK_RST  = 32'd2184;

    // CSR numbers
    localparam logic [11:0] CSR_MSTATUS    = 12'h300;
    localparam logic [11:0] CSR_MISA       = 12'h301;
    localparam logic [11:0] CSR_MIE        = 12'h304;
    localparam logic [11:0] CSR_MTVEC      = 12'h305;
    localparam logic [11:0] CSR_MSTATUSH   = 12'h310;
    localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
    localparam logic [11:0] CSR_MEPC       = 12'h341;
    localparam logic [11:0] CSR_MCAUSE     = 12'h342;
    localparam logic [11:0] CSR_MTVAL      = 12'h343;
    localparam logic [11:0] CSR_MIP        = 12'h344;
    localparam logic [11:0] CSR_MVENDORID  = 12'hF11;
    localparam logic [11:0] CSR_MARCHID    = 12'hF12;
    localparam logic [11:0] CSR_MIMPID     = 12'hF13;
    localparam logic [11:0] CSR_MHARTID    = 12'hF14;
    localparam logic [11:0] CSR_MCONFIGPTR = 12'hF15;

    // Exception cause codes
    localparam logic [XLEN-1:0] CAUSE_ILLEGAL = 32'd2;
    localparam logic [XLEN-1:0] CAUSE_UECALL  = 32'd8;
    localparam logic [XLEN-1:0] CAUSE_MECALL  = 32'd11;

    // Status bit positions in the packed status field
    localparam int unsigned ST_MIE  = 0;
    localparam int unsigned ST_MPIE = 1;
    localparam int unsigned ST_MPP  = 2;

    // Operation codes
    typedef enum logic [2:0] {
        OP_SWAP  = 3'd0,
        OP_SET   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_ECALL = 3'd3,
        OP_MRET  = 3'd4,
        OP_TRAP  = 3'd5
    } t_op;

    // Input item
    typedef struct packed {
        logic [2:0]      op;
        logic [11:0]     csr_address;
        logic [XLEN-1:0] write_data;
        logic [XLEN-1:0] current_pc;
        logic [XLEN-1:0] trap_cause;
        logic [XLEN-1:0] trap_value;
        logic [XLEN-1:0] irq_pending;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic            redirect;
        logic [XLEN-1:0] next_pc;
        logic            took_trap;
        logic            privilege_after;
    } t_out_item;

    // Architectural state of the hart's machine CSRs
    typedef struct packed {
        logic [2:0]      status;
        logic [XLEN-1:0] mie;
        logic [XLEN-1:0] mtvec;
        logic [XLEN-1:0] mscratch;
        logic [XLEN-1:0] mepc;
        logic [XLEN-1:0] mcause;
        logic [XLEN-1:0] mtval;
        logic            user;
    } t_csr_state;

    // Configuration registers
    typedef struct packed {
        logic [25:0]     isa_mask;
        logic [XLEN-1:0] ie_mask;
        logic            compressed;
    } t_cfg;

endpackage

>>> sv/mcsr_exec.sv
// Combinational CSR access, trap entry and trap return for one item.
`timescale 1ns / 1ps

module mcsr_exec (
    input  mcsr_pkg::t_in_item   i_item,
    input  mcsr_pkg::t_csr_state i_state,
    input  mcsr_pkg::t_cfg       i_cfg,
    output mcsr_pkg::t_csr_state o_state,
    output mcsr_pkg::t_out_item  o_res
);
    import mcsr_pkg::*;

    always_comb begin
        logic [XLEN-1:0] old_v;
        logic [XLEN-1:0] new_v;
        logic [XLEN-1:0] epc_al;
        logic [XLEN-1:0] cause;
        logic            rd_ok;
        logic            wr_ok;
        logic            trap;

        o_state = i_state;
        o_res   = '0;
        trap    = 1'b0;
        cause   = CAUSE_ILLEGAL;
        wr_ok   = 1'b1;
        new_v   = '0;

        // mepc as seen on a read or a return
        epc_al = i_state.mepc & (i_cfg.compressed ? ~32'd1 : ~32'd3);

        // CSR read mux
        rd_ok = 1'b1;
        unique case (i_item.csr_address)
            CSR_MSTATUS:  old_v = {19'd0, {2{i_state.status[ST_MPP]}}, 3'd0,
                                   i_state.status[ST_MPIE], 3'd0,
                                   i_state.status[ST_MIE], 3'd0};
            CSR_MISA:     old_v = {2'b01, 4'd0, i_cfg.isa_mask};
            CSR_MIE:      old_v = i_state.mie;
            CSR_MTVEC:    old_v = i_state.mtvec;
            CSR_MSTATUSH: old_v = '0;
            CSR_MSCRATCH: old_v = i_state.mscratch;
            CSR_MEPC:     old_v = epc_al;
            CSR_MCAUSE:   old_v = i_state.mcause;
            CSR_MTVAL:    old_v = i_state.mtval;
            CSR_MIP:      old_v = i_item.irq_pending;
            CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID, CSR_MCONFIGPTR:
                          old_v = '0;
            default: begin
                old_v = '0;
                rd_ok = 1'b0;
            end
        endcase

        unique case (i_item.op)
            OP_SWAP, OP_SET, OP_CLEAR: begin
                if (i_state.user || !rd_ok) begin
                    trap = 1'b1;
                end else begin
                    unique case (i_item.op)
                        OP_SWAP:  new_v = i_item.write_data;
                        OP_SET:   new_v = old_v | i_item.write_data;
                        default:  new_v = old_v & ~i_item.write_data;
                    endcase
                    // CSR write; read-only ID registers refuse every write
                    unique case (i_item.csr_address)
                        CSR_MSTATUS: begin
                            o_state.status[ST_MIE]  = new_v[3];
                            o_state.status[ST_MPIE] = new_v[7];
                            o_state.status[ST_MPP]  = |new_v[12:11];
                        end
                        CSR_MISA, CSR_MSTATUSH, CSR_MIP: ;
                        CSR_MIE:      o_state.mie      = new_v & i_cfg.ie_mask;
                        CSR_MTVEC:    o_state.mtvec    = new_v & ~32'd3;
                        CSR_MSCRATCH: o_state.mscratch = new_v;
                        CSR_MEPC:     o_state.mepc     = new_v;
                        CSR_MCAUSE:   o_state.mcause   = new_v;
                        CSR_MTVAL:    o_state.mtval    = new_v;
                        default:      wr_ok = 1'b0;
                    endcase
                    if (!wr_ok) begin
                        trap = 1'b1;
                    end else begin
                        o_res.read_data = old_v;
                    end
                end
            end
            OP_ECALL: begin
                trap  = 1'b1;
                cause = i_state.user ? CAUSE_UECALL : CAUSE_MECALL;
            end
            OP_MRET: begin
                if (i_state.user) begin
                    trap = 1'b1;
                end else begin
                    o_res.redirect = 1'b1;
                    o_res.next_pc  = epc_al;
                    o_state.user   = ~i_state.status[ST_MPP];
                    o_state.status[ST_MIE]  = i_state.status[ST_MPIE];
                    o_state.status[ST_MPIE] = 1'b1;
                    o_state.status[ST_MPP]  = 1'b0;
                end
            end
            OP_TRAP: begin
                trap  = 1'b1;
                cause = i_item.trap_cause;
            end
            default: ;
        endcase

        // Trap entry
        if (trap) begin
            o_state.mcause = cause;
            o_state.mtval  = (i_item.op == OP_TRAP) ? i_item.trap_value : '0;
            o_state.mepc   = i_item.current_pc;
            o_state.status[ST_MIE]  = 1'b0;
            o_state.status[ST_MPIE] = i_state.status[ST_MIE];
            o_state.status[ST_MPP]  = ~i_state.user;
            o_state.user            = 1'b0;
            o_res.read_data = '0;
            o_res.redirect  = 1'b1;
            o_res.next_pc   = i_state.mtvec;
            o_res.took_trap = 1'b1;
        end

        o_res.privilege_after = ~o_state.user;
    end

endmodule

>>> sv/machine_mode_csr_trap_unit_top.sv
// Top level of the machine-mode CSR and trap unit: input stage, CSR state and result register.
// Usage
//   Input channel: i_in_valid / o_in_stall carry one system operation per transfer
//   (CSR swap, set or clear, ecall, mret or external trap) in i_in_data.
//   Output channel: o_out_valid / i_out_stall carry one result per item in o_out_data:
//   old CSR value, redirect flag and next PC, trap flag and privilege afterwards.
//   Configuration: i_cfg_we with i_cfg_index and i_cfg_data writes the extension mask,
//   writable-mie mask or compressed flag; write only while the unit is idle.
// Timing
//   An item is captured in the input register when it transfers, and its result is then
//   loaded into the result register once that register is free. One item per cycle is
//   sustained while the output is not stalled: the CSR update is a single pass of logic
//   between the input register and the result register.
// Reset
//   Synchronous, active low: both channels empty, all CSRs zero, machine mode,
//   configuration back to its defaults.
// Back-pressure
//   A stalled result holds in the result register; one further item waits in the input
//   register, and o_in_stall rises only when both are occupied and the output is stalled.
`timescale 1ns / 1ps

module machine_mode_csr_trap_unit_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mcsr_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mcsr_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [mcsr_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mcsr_pkg::XLEN-1:0]             i_cfg_data
);
    import mcsr_pkg::*;

    logic       r_in_vld;
    t_in_item   r_in;
    logic       r_out_vld;
    t_out_item  r_out;
    t_csr_state r_state;
    t_csr_state n_state;
    t_out_item  n_out;
    t_cfg       r_cfg;
    logic       w_out_free;
    logic       w_fire;
    logic       w_in_take;

    // Handshake control
    assign w_out_free = ~r_out_vld | ~i_out_stall;
    assign w_fire     = r_in_vld & w_out_free;
    assign w_in_take  = i_in_valid & ~o_in_stall;
    assign o_in_stall = r_in_vld & ~w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
    end

    // Per-item CSR logic
    mcsr_exec u_exec (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // CSR state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.isa_mask   <= ISA_MASK_RST;
            r_cfg.ie_mask    <= IE_MASK_RST;
            r_cfg.compressed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ISA_MASK: r_cfg.isa_mask   <= i_cfg_data[25:0];
                CFG_IE_MASK:  r_cfg.ie_mask    <= i_cfg_data;
                CFG_COMPRESS: r_cfg.compressed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A trap result always redirects and lands in machine mode
    a_trap_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.took_trap |-> r_out.redirect && r_out.privilege_after)
        else $error("trap result without redirect to machine mode");

    // A trapping item never returns CSR data
    a_trap_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.took_trap |-> r_out.read_data == '0)
        else $error("trap result carries read data");

    // A stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> !(r_out_vld && i_out_stall))
        else $error("result register overwritten while stalled");

    // Privilege reported matches the state left behind
    a_priv_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out.privilege_after == ~r_state.user)
        else $error("privilege_after disagrees with state");

    // Trap vector base stays word aligned
    a_mtvec_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mtvec[1:0] == 2'b00)
        else $error("mtvec low bits set");

endmodule
